@@ hdl/cdq_pkg.sv @@
package cdq_pkg;

    // Default store depth and fixed field widths.
    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CAP_W     = 5;
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;

    // Reset value of the capacity register.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Byte address of the capacity register.
    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 2'd0;

    // Command codes carried by a request.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    // Status codes carried by a result.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY_DUMP = 2'd3;

    // Request and result payloads.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
    } cdq_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic                last;
    } cdq_rsp_t;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_DUMP
    } cdq_op_kind_t;

    typedef struct packed {
        cdq_op_kind_t      kind;
        logic [DATA_W-1:0] value;
    } cdq_op_t;

    // Back end states.
    typedef enum logic {
        BK_RUN,
        BK_DUMP
    } cdq_back_state_t;

endpackage

@@ hdl/cdq_ram.sv @@
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/cdq_front.sv @@
module cdq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cdq_pkg::cdq_req_t request,
    output cdq_pkg::cdq_op_t  op,
    output logic              op_valid,
    input  logic              op_take
);

    localparam int Q_DEPTH = 2;

    cdq_pkg::cdq_op_t     entry_reg [Q_DEPTH];
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 wr_ptr_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_reg;
    logic                 rd_ptr_next;
    logic                 cmd_ok;
    cdq_pkg::cdq_op_kind_t kind;
    logic                 enq;
    logic                 deq;

    // Classify the command; unknown codes are accepted and dropped.
    always_comb
    begin
        cmd_ok = 1'b1;
        kind   = cdq_pkg::OP_DUMP;
        case (request.cmd)
            cdq_pkg::CMD_PUSH_FRONT: kind = cdq_pkg::OP_PUSH_FRONT;
            cdq_pkg::CMD_PUSH_BACK:  kind = cdq_pkg::OP_PUSH_BACK;
            cdq_pkg::CMD_POP_FRONT:  kind = cdq_pkg::OP_POP_FRONT;
            cdq_pkg::CMD_POP_BACK:   kind = cdq_pkg::OP_POP_BACK;
            cdq_pkg::CMD_DUMP:       kind = cdq_pkg::OP_DUMP;
            default:                 cmd_ok = 1'b0;
        endcase
    end

    // The front end is busy only while the operation queue is full.
    assign busy     = (count_reg == 2'(Q_DEPTH));
    assign enq      = start && !busy && cmd_ok;
    assign deq      = op_take && op_valid;
    assign op_valid = (count_reg != 2'd0);
    assign op       = entry_reg[rd_ptr_reg];

    // Queue pointer and occupancy update.
    always_comb
    begin
        count_next  = count_reg + 2'(enq) - 2'(deq);
        wr_ptr_next = enq ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? !rd_ptr_reg : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Queue entries hold payload only.
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= '{kind: kind, value: request.value};
        end
    end

endmodule

@@ hdl/cdq_back.sv @@
module cdq_back #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cdq_pkg::cdq_op_t            op,
    input  logic                        op_valid,
    output logic                        op_take,
    input  logic [$clog2(DEPTH+1)-1:0]  ring_n,
    input  logic                        clear,
    output logic                        strobe,
    output cdq_pkg::cdq_rsp_t           result
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int CW    = NW + 1;

    cdq_pkg::cdq_back_state_t state_reg;
    cdq_pkg::cdq_back_state_t state_next;
    logic [IDX_W-1:0]         head_reg;
    logic [IDX_W-1:0]         head_next;
    logic [IDX_W-1:0]         tail_reg;
    logic [IDX_W-1:0]         tail_next;
    logic                     empty_reg;
    logic                     empty_next;
    logic [IDX_W-1:0]         walk_idx_reg;
    logic [IDX_W-1:0]         walk_idx_next;
    logic [NW-1:0]            walk_cnt_reg;
    logic [NW-1:0]            walk_cnt_next;
    logic                     strobe_reg;
    logic                     strobe_next;
    logic [cdq_pkg::STATUS_W-1:0] status_reg;
    logic [cdq_pkg::STATUS_W-1:0] status_next;
    logic                     last_reg;
    logic                     last_next;
    logic                     from_ram_reg;
    logic                     from_ram_next;
    logic                     full;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic                     ram_re;
    logic [IDX_W-1:0]         ram_raddr;
    logic [cdq_pkg::DATA_W-1:0] ram_rdata;

    // Next slot round the ring of n slots.
    function automatic logic [IDX_W-1:0] slot_up(input logic [IDX_W-1:0] i,
                                                 input logic [NW-1:0] n);
        logic [CW-1:0] top_slot;
        top_slot = CW'(n) - CW'(1);
        if (CW'(i) == top_slot)
            slot_up = '0;
        else
            slot_up = i + 1'b1;
    endfunction

    // Previous slot round the ring of n slots.
    function automatic logic [IDX_W-1:0] slot_down(input logic [IDX_W-1:0] i,
                                                   input logic [NW-1:0] n);
        logic [NW-1:0] top_slot;
        top_slot = n - 1'b1;
        if (i == '0)
            slot_down = IDX_W'(top_slot);
        else
            slot_down = i - 1'b1;
    endfunction

    // A dump ends at the back word or once a full ring has been listed.
    function automatic logic walk_end(input logic [IDX_W-1:0] i,
                                      input logic [IDX_W-1:0] t,
                                      input logic [NW-1:0] k,
                                      input logic [NW-1:0] n);
        walk_end = (i == t) || ((CW'(k) + CW'(1)) >= CW'(n));
    endfunction

    assign full = !empty_reg && (slot_up(tail_reg, ring_n) == head_reg);

    // Ring store.
    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (op.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Execute one operation per cycle, or one dump word per cycle.
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        empty_next    = empty_reg;
        walk_idx_next = walk_idx_reg;
        walk_cnt_next = walk_cnt_reg;
        strobe_next   = 1'b0;
        status_next   = cdq_pkg::ST_OK;
        last_next     = 1'b1;
        from_ram_next = 1'b0;
        op_take       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = head_reg;
        ram_re        = 1'b0;
        ram_raddr     = head_reg;

        case (state_reg)
            cdq_pkg::BK_RUN:
            begin
                if (op_valid)
                begin
                    op_take     = 1'b1;
                    strobe_next = 1'b1;
                    case (op.kind)
                        cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = cdq_pkg::ST_OVERFLOW;
                            end
                            else if (empty_reg)
                            begin
                                head_next  = '0;
                                tail_next  = '0;
                                empty_next = 1'b0;
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                            end
                            else if (op.kind == cdq_pkg::OP_PUSH_FRONT)
                            begin
                                head_next = slot_down(head_reg, ring_n);
                                ram_we    = 1'b1;
                                ram_waddr = head_next;
                            end
                            else
                            begin
                                tail_next = slot_up(tail_reg, ring_n);
                                ram_we    = 1'b1;
                                ram_waddr = tail_next;
                            end
                        end
                        cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK:
                        begin
                            if (empty_reg)
                            begin
                                status_next = cdq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                ram_re        = 1'b1;
                                from_ram_next = 1'b1;
                                ram_raddr     = (op.kind == cdq_pkg::OP_POP_FRONT)
                                                ? head_reg : tail_reg;
                                if (head_reg == tail_reg)
                                begin
                                    head_next  = '0;
                                    tail_next  = '0;
                                    empty_next = 1'b1;
                                end
                                else if (op.kind == cdq_pkg::OP_POP_FRONT)
                                begin
                                    head_next = slot_up(head_reg, ring_n);
                                end
                                else
                                begin
                                    tail_next = slot_down(tail_reg, ring_n);
                                end
                            end
                        end
                        cdq_pkg::OP_DUMP:
                        begin
                            if (empty_reg)
                            begin
                                status_next = cdq_pkg::ST_EMPTY_DUMP;
                            end
                            else
                            begin
                                ram_re        = 1'b1;
                                from_ram_next = 1'b1;
                                ram_raddr     = head_reg;
                                last_next     = walk_end(head_reg, tail_reg, '0, ring_n);
                                if (!last_next)
                                begin
                                    state_next    = cdq_pkg::BK_DUMP;
                                    walk_idx_next = slot_up(head_reg, ring_n);
                                    walk_cnt_next = NW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            cdq_pkg::BK_DUMP:
            begin
                ram_re        = 1'b1;
                ram_raddr     = walk_idx_reg;
                strobe_next   = 1'b1;
                from_ram_next = 1'b1;
                last_next     = walk_end(walk_idx_reg, tail_reg, walk_cnt_reg, ring_n);
                if (last_next)
                begin
                    state_next = cdq_pkg::BK_RUN;
                end
                else
                begin
                    walk_idx_next = slot_up(walk_idx_reg, ring_n);
                    walk_cnt_next = walk_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = cdq_pkg::BK_RUN;
            end
        endcase

        // Capacity write empties queue; user issues it idle; unchecked.
        if (clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cdq_pkg::BK_RUN;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
            walk_idx_reg <= '0;
            walk_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
            status_reg   <= cdq_pkg::ST_OK;
            last_reg     <= 1'b0;
            from_ram_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            empty_reg    <= empty_next;
            walk_idx_reg <= walk_idx_next;
            walk_cnt_reg <= walk_cnt_next;
            strobe_reg   <= strobe_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
            from_ram_reg <= from_ram_next;
        end
    end

    // Word results take the registered store output directly.
    assign strobe        = strobe_reg;
    assign result.status = status_reg;
    assign result.data   = from_ram_reg ? ram_rdata : '0;
    assign result.last   = last_reg;

    // An empty queue always has both ends parked on slot zero.
    a_empty_parked: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty queue with ends away from slot zero");

    // No new operation is taken while a dump is being walked.
    a_dump_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdq_pkg::BK_DUMP) |-> !op_take)
        else $error("operation taken during a dump");

    // Every dump cycle produces a result in the following cycle.
    a_dump_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cdq_pkg::BK_DUMP) |=> (strobe_reg && from_ram_reg))
        else $error("dump cycle without a result");

    // A word result always follows a store read.
    a_word_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> from_ram_reg)
        else $error("store read without a word result");

endmodule

@@ hdl/circular_deque.sv @@
// A request is registered in the front end's request queue and then, once the
// back end takes it, in the back end's result registers. One push or pop request
// per cycle while no dump is under way; a dump of k words holds the back end while
// it makes one store read per word, and the two-entry request queue then fills and raises busy.
// Reset: rst_n clears the queue to empty and capacity to 16; store contents
// are not cleared. Results cannot be stalled by the receiver.
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  cdq_pkg::cdq_req_t              request,
    output logic                           strobe,
    output cdq_pkg::cdq_rsp_t              result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cdq_pkg::PADDR_W-1:0]    paddr,
    input  logic [cdq_pkg::PDATA_W-1:0]    pwdata,
    output logic [cdq_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int NW = $clog2(DEPTH + 1);

    logic [cdq_pkg::CAP_W-1:0] capacity_reg;
    logic [cdq_pkg::CAP_W-1:0] capacity_next;
    logic                      cap_write;
    logic [NW-1:0]             ring_n;
    cdq_pkg::cdq_op_t          op;
    logic                      op_valid;
    logic                      op_take;

    // Register port: capacity is the only register.
    assign pready    = 1'b1;
    assign cap_write = psel && penable && pwrite && pready
                       && (paddr == cdq_pkg::ADDR_CAPACITY);
    assign capacity_next = cap_write ? pwdata[cdq_pkg::CAP_W-1:0] : capacity_reg;
    assign prdata    = (paddr == cdq_pkg::ADDR_CAPACITY)
                       ? cdq_pkg::PDATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= cdq_pkg::CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // Ring size: zero counts as one, and it never exceeds the store depth.
    always_comb
    begin
        if (capacity_reg == '0)
            ring_n = NW'(1);
        else if (32'(capacity_reg) > 32'(DEPTH))
            ring_n = NW'(DEPTH);
        else
            ring_n = NW'(capacity_reg);
    end

    // Front end: accepts and classifies requests into a short queue.
    cdq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .op       (op),
        .op_valid (op_valid),
        .op_take  (op_take)
    );

    // Back end: runs operations against the ring store.
    cdq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .op_valid (op_valid),
        .op_take  (op_take),
        .ring_n   (ring_n),
        .clear    (cap_write),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

@@ tb/sv/tb.sv @@
module tb;

    import cdq_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 70;

    // Capacity and sender idle percentage of each random phase.
    // The last phase picks its capacity at random.
    localparam int PHASE_CAP  [PHASES] = '{16, 1, 31, 9, 16, 0};
    localparam int PHASE_IDLE [PHASES] = '{0, 56, 56, 36, 36, 0};

    // Tracks the deque contents and holds the results still owed by the block.
    class deque_tracker;
        logic [DATA_W-1:0]  slot_word [DEPTH_DEF];
        logic [CAP_W-1:0]   cap_reg;
        int                 front_slot;
        int                 back_slot;
        bit                 ring_vacant;
        cdq_rsp_t           owed_results [$];
        int                 mismatches;
        int                 checked;
        int                 status_seen [4];

        function new();
            cap_reg     = CAP_RESET;
            front_slot  = 0;
            back_slot   = 0;
            ring_vacant = 1'b1;
            mismatches  = 0;
            checked     = 0;
            foreach (status_seen[s])
                status_seen[s] = 0;
        endfunction

        // A capacity write empties the queue but keeps the stored words.
        function void set_capacity(logic [CAP_W-1:0] cap);
            cap_reg     = cap;
            front_slot  = 0;
            back_slot   = 0;
            ring_vacant = 1'b1;
        endfunction

        function void owe(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] d, logic lst);
            cdq_rsp_t r;
            r.status = st;
            r.data   = d;
            r.last   = lst;
            owed_results.insert(owed_results.size(), r);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Works out the results of one accepted request and updates the queue.
        function void note_request(cdq_req_t req);
            int n;
            int k;
            int i;
            bit full;
            bit stop;
            logic [DATA_W-1:0] word;
            n = (cap_reg == '0) ? 1 : (int'(cap_reg) > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
            front_slot = front_slot % n;
            back_slot  = back_slot % n;
            full = !ring_vacant && ((back_slot + 1) % n == front_slot);
            case (req.cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        owe(ST_OVERFLOW, '0, 1'b1);
                    end
                    else
                    begin
                        if (ring_vacant)
                        begin
                            // The first word always lands in slot zero.
                            front_slot   = 0;
                            back_slot    = 0;
                            ring_vacant  = 1'b0;
                            slot_word[0] = req.value;
                        end
                        else if (req.cmd == CMD_PUSH_FRONT)
                        begin
                            front_slot = (front_slot + n - 1) % n;
                            slot_word[front_slot] = req.value;
                        end
                        else
                        begin
                            back_slot = (back_slot + 1) % n;
                            slot_word[back_slot] = req.value;
                        end
                        owe(ST_OK, '0, 1'b1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (ring_vacant)
                    begin
                        owe(ST_UNDERFLOW, '0, 1'b1);
                    end
                    else
                    begin
                        word = slot_word[(req.cmd == CMD_POP_FRONT) ? front_slot : back_slot];
                        if (front_slot == back_slot)
                        begin
                            front_slot  = 0;
                            back_slot   = 0;
                            ring_vacant = 1'b1;
                        end
                        else if (req.cmd == CMD_POP_FRONT)
                        begin
                            front_slot = (front_slot + 1) % n;
                        end
                        else
                        begin
                            back_slot = (back_slot + n - 1) % n;
                        end
                        owe(ST_OK, word, 1'b1);
                    end
                end
                CMD_DUMP:
                begin
                    if (ring_vacant)
                    begin
                        owe(ST_EMPTY_DUMP, '0, 1'b1);
                    end
                    else
                    begin
                        // Walk from front to back, never more than the ring holds.
                        k    = 0;
                        i    = front_slot;
                        stop = 1'b0;
                        while (!stop)
                        begin
                            stop = (i == back_slot) || (k + 1 >= n);
                            owe(ST_OK, slot_word[i], stop);
                            k++;
                            i = (i + 1) % n;
                        end
                    end
                end
                default:
                begin
                    // Unknown commands are dropped without a result.
                end
            endcase
        endfunction

        // Compares one result with the oldest one owed.
        function void check_result(cdq_rsp_t got);
            cdq_rsp_t want;
            if (owed_results.size() == 0)
            begin
                $error("result with none expected: status %0d data %h last %0d",
                       got.status, got.data, got.last);
                mismatches++;
                return;
            end
            want = owed_results[0];
            owed_results.delete(0);
            checked++;
            status_seen[want.status]++;
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.data !== want.data)
            begin
                $error("data: expected %h, got %h", want.data, got.data);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    cdq_req_t            request;
    logic                strobe;
    cdq_rsp_t            result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    deque_tracker        sb;
    int                  accepted;
    int                  cap_writes;
    int                  quiet_cycles;

    circular_deque dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Note each accepted request, check each result and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_request(request);
                accepted++;
            end
            if (strobe)
                sb.check_result(result);
            if ((start && !busy) || strobe)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb: FAIL");
                    $finish;
                end
            end
        end
    end

    // Presents one request, after a random number of idle cycles, and holds
    // it until the block takes it.
    task automatic send_cmd(logic [CMD_W-1:0] c, logic [DATA_W-1:0] v, int idle_pct);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= '{cmd: c, value: v};
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stops sending and waits until every owed result has arrived.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the capacity register through a setup and an access phase.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= {{(PDATA_W-CAP_W){1'b0}}, cap};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_capacity(cap);
        cap_writes++;
    endtask

    initial
    begin
        int cap;
        int push_pct;
        int pick;
        logic [CMD_W-1:0] c;

        sb           = new();
        accepted     = 0;
        cap_writes   = 0;
        quiet_cycles = 0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on a two-slot ring: empty errors, fill, overflow at
        // both ends, dump, pops down to empty and ignored commands.
        write_capacity(CAP_W'(2));
        send_cmd(CMD_POP_FRONT, $urandom, 0);
        send_cmd(CMD_POP_BACK, $urandom, 0);
        send_cmd(CMD_DUMP, $urandom, 0);
        send_cmd(CMD_PUSH_BACK, '1, 0);
        send_cmd(CMD_PUSH_FRONT, '0, 0);
        send_cmd(CMD_PUSH_BACK, 32'h1234_5678, 0);
        send_cmd(CMD_PUSH_FRONT, 32'hA5A5_A5A5, 0);
        send_cmd(CMD_DUMP, $urandom, 0);
        send_cmd(CMD_POP_BACK, $urandom, 0);
        send_cmd(CMD_POP_FRONT, $urandom, 0);
        send_cmd(CMD_DUMP, $urandom, 0);
        send_cmd(CMD_DUMP + CMD_W'(1), $urandom, 0);
        send_cmd({CMD_W{1'b1}}, $urandom, 0);
        send_cmd(CMD_PUSH_FRONT, 32'h5A5A_5A5A, 0);
        send_cmd(CMD_POP_BACK, $urandom, 0);
        send_cmd(CMD_PUSH_BACK, $urandom, 0);
        send_cmd(CMD_PUSH_FRONT, $urandom, 0);
        send_cmd(CMD_POP_FRONT, $urandom, 0);
        send_cmd(CMD_DUMP, $urandom, 0);
        wait_drained();

        // A capacity of zero behaves as a single slot.
        write_capacity('0);
        send_cmd(CMD_PUSH_FRONT, $urandom, 0);
        send_cmd(CMD_PUSH_BACK, $urandom, 0);
        send_cmd(CMD_DUMP, $urandom, 0);
        send_cmd(CMD_POP_BACK, $urandom, 0);
        send_cmd(CMD_POP_FRONT, $urandom, 0);
        wait_drained();

        // Random phases, each with its own capacity and sender idling.
        // Push-heavy and pop-heavy stretches alternate so the ring keeps
        // swinging between full and empty.
        for (int p = 0; p < PHASES; p++)
        begin
            cap = (p == PHASES - 1) ? int'($urandom_range(1, DEPTH_DEF)) : PHASE_CAP[p];
            write_capacity(CAP_W'(cap));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                push_pct = ((i / 12) % 2 == 0) ? 70 : 25;
                pick     = $urandom_range(99);
                if (pick < push_pct)
                    c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else if (pick < 90)
                    c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
                else if (pick < 97)
                    c = CMD_DUMP;
                else
                    c = CMD_W'($urandom_range(int'(CMD_DUMP) + 1, (1 << CMD_W) - 1));
                send_cmd(c, $urandom, PHASE_IDLE[p]);
                // Now and then let the block run dry before carrying on.
                if ($urandom_range(49) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        if (sb.pending() != 0)
        begin
            $error("%0d results never arrived", sb.pending());
            sb.mismatches++;
        end

        $display("tb: %0d requests accepted, %0d results checked, %0d capacity writes",
                 accepted, sb.checked, cap_writes);
        $display("tb: ok %0d, overflow %0d, underflow %0d, empty dump %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_OVERFLOW],
                 sb.status_seen[ST_UNDERFLOW], sb.status_seen[ST_EMPTY_DUMP]);
        if (sb.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hdl/cdq_pkg.sv
hdl/cdq_ram.sv
hdl/cdq_front.sv
hdl/cdq_back.sv
hdl/circular_deque.sv
tb/sv/tb.sv
